/* rtl/assert_macros.svh */
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/ksq_pkg.sv */
// Shared types, constants and scancode translation for the keycode queue.
package ksq_pkg;

  localparam int DefQueueDepth = 1024;

  localparam int InDataW  = 16;
  localparam int OutDataW = 24;
  localparam int SeqMaxLen = 6;
  localparam int SeqBitsW  = 8 * SeqMaxLen;

  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;

  localparam logic [9:0] KC_102ND = 10'd86;
  localparam logic [9:0] KC_F11   = 10'd87;
  localparam logic [9:0] KC_F12   = 10'd88;
  localparam logic [9:0] KC_PAUSE = 10'd119;
  localparam logic [9:0] KC_LAST_PLAIN = 10'd83;

  localparam logic [7:0] SC_E0       = 8'hE0;
  localparam logic [7:0] SC_E1       = 8'hE1;
  localparam logic [7:0] SC_BREAK    = 8'h80;
  localparam logic [7:0] SC_102ND    = 8'h56;
  localparam logic [SeqBitsW-1:0] SC_PAUSE_SEQ = 48'hE1_1D_45_E1_9D_C5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } ksq_state_t;

  typedef struct packed {
    logic load;
    logic write_step;
    logic pop_step;
    logic result_load;
  } ksq_cmd_t;

  typedef struct packed {
    logic seq_empty;
    logic seq_last;
    logic out_free;
  } ksq_status_t;

  // Byte sequence: first byte in the top bits.
  typedef struct packed {
    logic [2:0]          len;
    logic [SeqBitsW-1:0] bytes;
  } ksq_seq_t;

  // Base code behind the E0 prefix; zero when not a gray key.
  function automatic logic [7:0] gray_base(input logic [9:0] kc);
    logic [7:0] code;
    case (kc)
      10'd96:  code = 8'h1C;
      10'd97:  code = 8'h1D;
      10'd98:  code = 8'h35;
      10'd99:  code = 8'h37;
      10'd100: code = 8'h38;
      10'd102: code = 8'h47;
      10'd103: code = 8'h48;
      10'd104: code = 8'h49;
      10'd105: code = 8'h4B;
      10'd106: code = 8'h4D;
      10'd107: code = 8'h4F;
      10'd108: code = 8'h50;
      10'd109: code = 8'h51;
      10'd110: code = 8'h52;
      10'd111: code = 8'h53;
      10'd125: code = 8'h5B;
      10'd126: code = 8'h5C;
      10'd127: code = 8'h5D;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic ksq_seq_t translate(input logic [9:0] kc, input logic [1:0] act);
    ksq_seq_t   seq;
    logic [7:0] code;
    logic [7:0] gray;
    logic [7:0] brk;
    seq  = '0;
    gray = gray_base(kc);
    brk  = (act == ACT_RELEASE) ? SC_BREAK : 8'h00;
    code = 8'h00;
    if (kc == KC_PAUSE) begin
      if (act == ACT_PRESS) begin
        seq.len   = 3'(SeqMaxLen);
        seq.bytes = SC_PAUSE_SEQ;
      end
    end else if ((kc >= 10'd1 && kc <= KC_LAST_PLAIN) || kc == KC_F11 || kc == KC_F12) begin
      code      = kc[7:0] | brk;
      seq.len   = 3'd1;
      seq.bytes = {code, 40'h0};
    end else if (kc == KC_102ND) begin
      code      = SC_102ND | brk;
      seq.len   = 3'd1;
      seq.bytes = {code, 40'h0};
    end else if (gray != 8'h00) begin
      code      = gray | brk;
      seq.len   = 3'd2;
      seq.bytes = {SC_E0, code, 32'h0};
    end
    return seq;
  endfunction

endpackage

/* rtl/ksq_ctrl.sv */
// Controller state machine: sequences accept, queue writes, pop read and result load.
module ksq_ctrl import ksq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_kind,
  input  ksq_status_t status,
  output logic        in_tready,
  output ksq_cmd_t    cmd
);

  ksq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_kind) begin
            state_nxt = ST_READ;
          end else if (status.seq_empty) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd.write_step = 1'b1;
        if (status.seq_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.pop_step = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ksq_dpath.sv */
// Datapath: byte sequence register, queue memory with pointers, output register.
module ksq_dpath import ksq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [InDataW-1:0]  in_tdata,
  input  ksq_cmd_t            cmd,
  output ksq_status_t         status,
  output logic [AW-1:0]       level,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser
);

  localparam logic [AW-1:0] LevelMax = AW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] PtrLast  = AW'(QUEUE_DEPTH - 1);

  logic [7:0] mem [QUEUE_DEPTH];

  logic [AW-1:0]       wr_ptr_r, rd_ptr_r, level_r;
  logic [SeqBitsW-1:0] seq_r;
  logic [2:0]          seq_cnt_r;
  logic [2:0]          queued_r;
  logic                pop_hit_r;
  logic [7:0]          rd_data_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                out_user_r;

  ksq_seq_t      seq_in;
  logic          can_write, can_pop;
  logic [7:0]    pop_byte;
  logic [AW+9:0] level_wide;

  assign seq_in    = translate(in_tdata[9:0], in_tdata[11:10]);
  assign can_write = cmd.write_step && (level_r != LevelMax);
  assign can_pop   = cmd.pop_step && (level_r != '0);
  assign pop_byte  = pop_hit_r ? rd_data_r : 8'h00;
  assign level_wide = {10'd0, level_r};

  assign status.seq_empty = (seq_in.len == 3'd0);
  assign status.seq_last  = (seq_cnt_r == 3'd1);
  assign status.out_free  = !out_valid_r || out_tready;

  assign level      = level_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // queue memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (can_write) begin
      mem[wr_ptr_r] <= seq_r[SeqBitsW-1 -: 8];
    end
    if (can_pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r     <= seq_in.bytes;
      seq_cnt_r <= seq_in.len;
    end else if (cmd.write_step) begin
      seq_r     <= {seq_r[SeqBitsW-9:0], 8'h00};
      seq_cnt_r <= seq_cnt_r - 3'd1;
    end
    if (cmd.result_load) begin
      out_data_r <= {3'b000, level_wide[9:0], pop_byte, queued_r};
      out_user_r <= pop_hit_r;
    end
  end

  // control state: pointers, level, counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      level_r     <= '0;
      queued_r    <= '0;
      pop_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        queued_r  <= '0;
        pop_hit_r <= 1'b0;
      end
      if (can_write) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + AW'(1);
        level_r  <= level_r + AW'(1);
        queued_r <= queued_r + 3'd1;
      end
      if (can_pop) begin
        rd_ptr_r  <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + AW'(1);
        level_r   <= level_r - AW'(1);
        pop_hit_r <= 1'b1;
      end
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/keycode_to_set1_scancode_queue_unit.sv */
// Top level of the key-event to AT set-1 scancode translator with byte queue.
//
// Usage:
//   Input stream (in_*): each transaction is a key event (in_tuser = 0) or a
//   pop request (in_tuser = 1). in_tdata carries key_code [9:0] and
//   key_action [11:10]. A key event is translated to set-1 bytes that are
//   appended to the queue; a pop removes the oldest queued byte.
//   Output stream (out_*): one result transaction per input transaction,
//   in order. out_tuser is pop_valid; out_tdata carries bytes_queued,
//   scan_byte and queue_level (low 10 bits of the level after the item).
// Timing:
//   One item at a time. An event goes from accept through one write step
//   per byte of its sequence (0..6 bytes, Pause press gives 6) to result
//   load, since the single queue memory write port takes one byte per cycle.
//   A pop goes through accept, registered memory read and result load.
//   in_tready is high again the cycle after the result is loaded, even
//   while that result still waits in the output register.
// Reset: synchronous, active low; empties the queue (pointers and level to
//   zero) and clears the output valid. Queue contents are not cleared.
// Stall: while out_tready is low the result register holds; a further
//   finished item waits in its final state until the register frees up.
module keycode_to_set1_scancode_queue_unit import ksq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // key_code [9:0], key_action [11:10], zero [15:12]
  input  logic                in_tuser,   // kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // bytes_queued [2:0], scan_byte [10:3],
                                          // queue_level [20:11], zero [23:21]
  output logic                out_tuser   // pop_valid
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);

  ksq_cmd_t      cmd;
  ksq_status_t   status;
  logic [AW-1:0] level;

  // Controller: decide which step the datapath takes each cycle.
  ksq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Datapath: translate, queue, pop and hold the result.
  ksq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .level      (level),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // The queue never holds more than QUEUE_DEPTH-1 bytes.
  `ASSERT_NEVER(a_level_bound, level > AW'(QUEUE_DEPTH - 1), "queue level above capacity")
  // No queue access while the input side is open.
  `ASSERT_NEVER(a_idle_no_access, in_tready && (cmd.write_step || cmd.pop_step),
                "queue access while idle")
  // A result never reports more bytes than the longest sequence.
  `ASSERT_CLK(a_queued_bound, out_tvalid |-> (out_tdata[2:0] <= 3'(SeqMaxLen)),
              "bytes_queued out of range")
  // A successful pop queues nothing.
  `ASSERT_CLK(a_pop_no_queue, (out_tvalid && out_tuser) |-> (out_tdata[2:0] == 3'd0),
              "pop result with queued bytes")

endmodule
